// ===== design/i2p_pkg.sv =====
package i2p_pkg;

    typedef enum logic [2:0] {
        CODE_NONE = 3'd0,
        CODE_OPEN = 3'd1,
        CODE_ADD  = 3'd2,
        CODE_SUB  = 3'd3,
        CODE_MUL  = 3'd4,
        CODE_DIV  = 3'd5,
        CODE_POW  = 3'd6
    } code_t;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_POW   = 8'h24;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [1:0] STAT_OK  = 2'd0;
    localparam logic [1:0] STAT_OVF = 2'd1;
    localparam logic [1:0] STAT_UNM = 2'd2;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    // stack cell shift control
    typedef struct packed {
        logic push;
        logic pop;
    } shift_t;

    // one result beat toward the output stage
    typedef struct packed {
        logic       valid;
        logic [7:0] chr;
        logic [1:0] status;
    } res_t;

    // end of item: release the held beat, or a bare end marker
    typedef struct packed {
        logic       valid;
        logic       last;
        logic [1:0] status;
    } fin_t;

    function automatic code_t op_code(input logic [7:0] ch);
        code_t c;
        unique case (ch)
            CH_PLUS:  c = CODE_ADD;
            CH_MINUS: c = CODE_SUB;
            CH_STAR:  c = CODE_MUL;
            CH_SLASH: c = CODE_DIV;
            CH_POW:   c = CODE_POW;
            default:  c = CODE_NONE;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] code_char(input code_t c);
        logic [7:0] ch;
        unique case (c)
            CODE_OPEN: ch = CH_LPAR;
            CODE_ADD:  ch = CH_PLUS;
            CODE_SUB:  ch = CH_MINUS;
            CODE_MUL:  ch = CH_STAR;
            CODE_DIV:  ch = CH_SLASH;
            CODE_POW:  ch = CH_POW;
            default:   ch = CH_NUL;
        endcase
        return ch;
    endfunction

    function automatic logic [1:0] code_weight(input code_t c);
        logic [1:0] w;
        unique case (c) inside
            CODE_ADD, CODE_SUB: w = 2'd1;
            CODE_MUL, CODE_DIV: w = 2'd2;
            CODE_POW:           w = 2'd3;
            default:            w = 2'd0;
        endcase
        return w;
    endfunction

    function automatic logic is_operand(input logic [7:0] ch);
        return (ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h41 && ch <= 8'h5A) ||
               (ch >= 8'h61 && ch <= 8'h7A);
    endfunction

endpackage

// ===== design/i2p_cell.sv =====
module i2p_cell (
    input  logic             aclk,
    input  i2p_pkg::shift_t  shift_i,
    input  i2p_pkg::code_t   up_i,
    input  i2p_pkg::code_t   down_i,
    output i2p_pkg::code_t   q_o
);

    i2p_pkg::code_t code_reg;

    always_ff @(posedge aclk) begin
        if (shift_i.push) begin
            code_reg <= up_i;
        end else if (shift_i.pop) begin
            code_reg <= down_i;
        end
    end

    assign q_o = code_reg;

endmodule

// ===== design/i2p_hold.sv =====
module i2p_hold (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  i2p_pkg::res_t                     res_i,
    output logic                              res_rdy_o,
    input  i2p_pkg::fin_t                     fin_i,
    output logic                              fin_rdy_o,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [i2p_pkg::OUT_TDATA_W-1:0]   m_tdata,  // [7:0] out_char, [9:8] status
    output logic [0:0]                        m_tuser,  // [0] char_valid
    output logic                              m_tlast   // last_of_expr
);

    logic       hold_valid_reg, hold_valid_next;
    logic [7:0] hold_char_reg, hold_char_next;
    logic [1:0] hold_stat_reg, hold_stat_next;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_char_reg, out_char_next;
    logic [1:0] out_stat_reg, out_stat_next;
    logic       out_cv_reg, out_cv_next;
    logic       out_last_reg, out_last_next;

    logic out_free;

    assign out_free  = !out_valid_reg || m_tready;
    assign res_rdy_o = !hold_valid_reg || out_free;
    assign fin_rdy_o = out_free;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        hold_char_next  = hold_char_reg;
        hold_stat_next  = hold_stat_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_char_next   = out_char_reg;
        out_stat_next   = out_stat_reg;
        out_cv_next     = out_cv_reg;
        out_last_next   = out_last_reg;

        if (res_i.valid && res_rdy_o) begin
            if (hold_valid_reg) begin
                out_valid_next = 1'b1;
                out_char_next  = hold_char_reg;
                out_stat_next  = hold_stat_reg;
                out_cv_next    = 1'b1;
                out_last_next  = 1'b0;
            end
            hold_valid_next = 1'b1;
            hold_char_next  = res_i.chr;
            hold_stat_next  = res_i.status;
        end else if (fin_i.valid && fin_rdy_o) begin
            if (hold_valid_reg) begin
                out_valid_next  = 1'b1;
                out_char_next   = hold_char_reg;
                out_stat_next   = hold_stat_reg;
                out_cv_next     = 1'b1;
                out_last_next   = fin_i.last;
                hold_valid_next = 1'b0;
            end else if (fin_i.last) begin
                out_valid_next = 1'b1;
                out_char_next  = i2p_pkg::CH_NUL;
                out_stat_next  = fin_i.status;
                out_cv_next    = 1'b0;
                out_last_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
        hold_char_reg <= hold_char_next;
        hold_stat_reg <= hold_stat_next;
        out_char_reg  <= out_char_next;
        out_stat_reg  <= out_stat_next;
        out_cv_reg    <= out_cv_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(i2p_pkg::OUT_TDATA_W - 10){1'b0}}, out_stat_reg, out_char_reg};
    assign m_tuser  = out_cv_reg;
    assign m_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    a_one_req: assert property (@(posedge aclk) disable iff (!aresetn)
        !(res_i.valid && fin_i.valid))
        else $error("result and finish requested together");

    a_fin_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_i.valid && fin_rdy_o |=> !hold_valid_reg)
        else $error("held beat survived finish");

    a_marker_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata[7:0] == i2p_pkg::CH_NUL)
        else $error("bare marker not last or not empty");
`endif

endmodule

// ===== design/infix_to_postfix_converter_core.sv =====
// Channel  Dir  tdata                         tuser          tlast
// s_       in   [7:0] in_char                 -              end_of_expr
// m_       out  [7:0] out_char, [9:8] status  [0] char_valid last_of_expr
//
// An item passes through the accept and execute states, then a flush state that
// empties the stack when it ends an expression, then the finish state; execute
// pops as the character needs. The stack is a shift chain of cells, one push or pop
// per cycle. Reset clears count, status and handshake state; the cells hold no
// reset. m_tready low stalls the pop sequence through the output hold stage.
module infix_to_postfix_converter_core #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [i2p_pkg::IN_TDATA_W-1:0]    s_tdata,  // [7:0] in_char
    input  logic                              s_tlast,  // end_of_expr
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [i2p_pkg::OUT_TDATA_W-1:0]   m_tdata,  // [7:0] out_char, [9:8] status
    output logic [0:0]                        m_tuser,  // [0] char_valid
    output logic                              m_tlast   // last_of_expr
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(STACK_DEPTH);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_FLUSH = 5'b00100,
        S_FIN   = 5'b01000,
        S_SPARE = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic [7:0]       char_reg;
    logic             last_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] open_reg, open_next;
    logic [1:0]       status_reg, status_next;

    i2p_pkg::shift_t  shift;
    i2p_pkg::code_t   push_code;
    i2p_pkg::code_t   cell_q [STACK_DEPTH];
    i2p_pkg::code_t   top_code, cur_code;
    i2p_pkg::res_t    res;
    i2p_pkg::fin_t    fin;
    logic             res_rdy, fin_rdy;
    logic             push_req;
    logic             pop_ok;
    logic             stk_empty;
    logic [1:0]       cur_w, top_w;
    state_t           after_item;

    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
            i2p_pkg::code_t up_c, down_c;
            if (gi == 0) begin : g_head
                assign up_c = push_code;
            end else begin : g_mid
                assign up_c = cell_q[gi-1];
            end
            if (gi == STACK_DEPTH - 1) begin : g_tail
                assign down_c = cell_q[gi];
            end else begin : g_body
                assign down_c = cell_q[gi+1];
            end
            i2p_cell u_cell (
                .aclk    (aclk),
                .shift_i (shift),
                .up_i    (up_c),
                .down_i  (down_c),
                .q_o     (cell_q[gi])
            );
        end
    endgenerate

    assign top_code   = cell_q[0];
    assign cur_code   = i2p_pkg::op_code(char_reg);
    assign cur_w      = i2p_pkg::code_weight(cur_code);
    assign top_w      = i2p_pkg::code_weight(top_code);
    assign stk_empty  = (count_reg == '0);
    assign after_item = last_reg ? S_FLUSH : S_FIN;
    assign pop_ok     = !stk_empty && top_code != i2p_pkg::CODE_OPEN &&
                        !(top_w < cur_w || (top_w == cur_w && top_code == i2p_pkg::CODE_POW));
    assign s_tready   = (state_reg == S_IDLE);

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        open_next   = open_reg;
        status_next = status_reg;
        shift       = '0;
        push_req    = 1'b0;
        push_code   = (char_reg == i2p_pkg::CH_LPAR) ? i2p_pkg::CODE_OPEN : cur_code;
        res         = '0;
        res.status  = status_reg;
        res.chr     = i2p_pkg::code_char(top_code);
        fin         = '0;
        fin.last    = last_reg;
        fin.status  = status_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_EXEC;
                    if (s_tdata[7:0] == i2p_pkg::CH_RPAR && open_reg == '0 &&
                        status_reg == i2p_pkg::STAT_OK) begin
                        status_next = i2p_pkg::STAT_UNM;
                    end
                end
            end
            S_EXEC: begin
                if (cur_code != i2p_pkg::CODE_NONE) begin
                    if (pop_ok) begin
                        res.valid = 1'b1;
                        if (res_rdy) begin
                            shift.pop  = 1'b1;
                            count_next = count_reg - CNT_W'(1);
                        end
                    end else begin
                        push_req   = 1'b1;
                        state_next = after_item;
                    end
                end else if (i2p_pkg::is_operand(char_reg)) begin
                    res.valid = 1'b1;
                    res.chr   = char_reg;
                    if (res_rdy) begin
                        state_next = after_item;
                    end
                end else if (char_reg == i2p_pkg::CH_LPAR) begin
                    push_req   = 1'b1;
                    state_next = after_item;
                end else if (char_reg == i2p_pkg::CH_RPAR) begin
                    if (!stk_empty && top_code != i2p_pkg::CODE_OPEN) begin
                        res.valid = 1'b1;
                        if (res_rdy) begin
                            shift.pop  = 1'b1;
                            count_next = count_reg - CNT_W'(1);
                        end
                    end else begin
                        if (!stk_empty) begin
                            shift.pop  = 1'b1;
                            count_next = count_reg - CNT_W'(1);
                            open_next  = open_reg - CNT_W'(1);
                        end
                        state_next = after_item;
                    end
                end else begin
                    state_next = after_item;
                end
            end
            S_FLUSH: begin
                if (!stk_empty) begin
                    res.valid = 1'b1;
                    if (res_rdy) begin
                        shift.pop  = 1'b1;
                        count_next = count_reg - CNT_W'(1);
                        if (top_code == i2p_pkg::CODE_OPEN) begin
                            open_next = open_reg - CNT_W'(1);
                        end
                    end
                end else begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                fin.valid = 1'b1;
                if (fin_rdy) begin
                    state_next = S_IDLE;
                    if (last_reg) begin
                        status_next = i2p_pkg::STAT_OK;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (push_req) begin
            if (count_reg < FULL) begin
                shift.push = 1'b1;
                count_next = count_reg + CNT_W'(1);
                if (push_code == i2p_pkg::CODE_OPEN) begin
                    open_next = open_reg + CNT_W'(1);
                end
            end else if (status_reg == i2p_pkg::STAT_OK) begin
                status_next = i2p_pkg::STAT_OVF;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            open_reg   <= '0;
            status_reg <= i2p_pkg::STAT_OK;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            open_reg   <= open_next;
            status_reg <= status_next;
        end
        if (s_tvalid && s_tready) begin
            char_reg <= s_tdata[7:0];
            last_reg <= s_tlast;
        end
    end

    i2p_hold u_hold (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_i     (res),
        .res_rdy_o (res_rdy),
        .fin_i     (fin),
        .fin_rdy_o (fin_rdy),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

`ifndef NO_ASSERTIONS
    a_open_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        open_reg <= count_reg)
        else $error("open paren count exceeds stack count");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL)
        else $error("stack count beyond depth");

    a_status_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_FIN && last_reg && fin_rdy |=> status_reg == i2p_pkg::STAT_OK)
        else $error("status not cleared after expression end");
`endif

endmodule
